// ===== src/rpd_pkg.sv =====
// Shared types, constants and helpers for the debug packet deframer.
`timescale 1ns / 1ps

package rpd_pkg;

    // Line buffer size; one entry is kept for a terminator
    localparam int LINE_BUF_SIZE = 4096;
    localparam int CNT_W         = $clog2(LINE_BUF_SIZE);
    localparam int LEN_W         = 12;

    typedef logic [CNT_W-1:0] count_t;

    localparam count_t CNT_MAX = CNT_W'(LINE_BUF_SIZE - 1);

    // Framing and ack characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_NONE   = 8'h00;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CSUM_HI = 2'd2,
        PH_CSUM_LO = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RT_DATA  = 2'd0,
        RT_GOOD  = 2'd1,
        RT_BAD   = 2'd2,
        RT_ABORT = 2'd3
    } rtype_t;

    // Word held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } in_word_t;

    // One result word
    typedef struct packed {
        rtype_t           rtype;
        logic [7:0]       data;
        logic [LEN_W-1:0] length;
        logic [7:0]       csum;
    } result_t;

    // Decode one hex digit; anything else counts as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// ===== src/rpd_in_stage.sv =====
// Input register that holds one received word until the parser takes it.
`timescale 1ns / 1ps

module rpd_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  logic             take,
    output rpd_pkg::in_word_t word
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    // Accept while empty or while the held word leaves this cycle
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the byte
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= rx_byte;
        end
    end

    assign word.valid = valid_reg;
    assign word.data  = data_reg;

endmodule

// ===== src/rpd_parser.sv =====
// Framing state machine: payload pass-through, running sum, count and verdict.
`timescale 1ns / 1ps

module rpd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  rpd_pkg::in_word_t word,
    input  logic              out_ready,
    output logic              take,
    output logic              res_fire,
    output rpd_pkg::result_t  res
);

    rpd_pkg::phase_t phase_reg;
    rpd_pkg::phase_t phase_next;
    logic [7:0]      sum_reg;
    logic [7:0]      sum_next;
    rpd_pkg::count_t count_reg;
    rpd_pkg::count_t count_next;
    rpd_pkg::count_t count_inc;
    logic [3:0]      hi_reg;
    logic [3:0]      hi_next;
    logic [3:0]      digit;
    logic [7:0]      rx_csum;
    logic [7:0]      c;

    // Process the held word when the result register can take a result
    assign take      = word.valid && out_ready;
    assign c         = word.data;
    assign digit     = rpd_pkg::hex_value(c);
    assign rx_csum   = {hi_reg, digit};
    assign count_inc = count_reg + rpd_pkg::count_t'(1);

    // Next state and result
    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        hi_next    = hi_reg;
        res_fire   = 1'b0;
        res.rtype  = rpd_pkg::RT_DATA;
        res.data   = c;
        res.length = rpd_pkg::LEN_W'(count_inc);
        res.csum   = 8'd0;
        if (take)
        begin
            case (phase_reg)
                rpd_pkg::PH_IDLE:
                begin
                    if (c == rpd_pkg::CH_DOLLAR)
                    begin
                        sum_next   = 8'd0;
                        count_next = '0;
                        phase_next = rpd_pkg::PH_PAYLOAD;
                    end
                end
                rpd_pkg::PH_PAYLOAD:
                begin
                    if (c == rpd_pkg::CH_HASH)
                    begin
                        phase_next = rpd_pkg::PH_CSUM_HI;
                    end
                    else if (count_reg >= rpd_pkg::CNT_MAX)
                    begin
                        // Drop the byte and abort the packet
                        phase_next = rpd_pkg::PH_IDLE;
                        res_fire   = 1'b1;
                        res.rtype  = rpd_pkg::RT_ABORT;
                        res.data   = rpd_pkg::CH_NONE;
                        res.length = rpd_pkg::LEN_W'(count_reg);
                    end
                    else
                    begin
                        count_next = count_inc;
                        sum_next   = sum_reg + c;
                        res_fire   = 1'b1;
                    end
                end
                rpd_pkg::PH_CSUM_HI:
                begin
                    hi_next    = digit;
                    phase_next = rpd_pkg::PH_CSUM_LO;
                end
                rpd_pkg::PH_CSUM_LO:
                begin
                    phase_next = rpd_pkg::PH_IDLE;
                    res_fire   = 1'b1;
                    res.length = rpd_pkg::LEN_W'(count_reg);
                    res.csum   = rx_csum;
                    if (rx_csum == sum_reg)
                    begin
                        res.rtype = rpd_pkg::RT_GOOD;
                        res.data  = rpd_pkg::CH_PLUS;
                    end
                    else
                    begin
                        res.rtype = rpd_pkg::RT_BAD;
                        res.data  = rpd_pkg::CH_MINUS;
                    end
                end
                default:
                begin
                    phase_next = rpd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rpd_pkg::PH_IDLE;
            sum_reg   <= 8'd0;
            count_reg <= '0;
            hi_reg    <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            hi_reg    <= hi_next;
        end
    end

    // Second checksum digit always closes the packet
    a_verdict_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == rpd_pkg::PH_CSUM_LO) |=> phase_reg == rpd_pkg::PH_IDLE)
        else $error("verdict did not return to idle");

    // Count never runs past the buffer limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rpd_pkg::CNT_MAX)
        else $error("byte count beyond buffer limit");

    // Results come only from payload or second checksum digit
    a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |-> (phase_reg == rpd_pkg::PH_PAYLOAD || phase_reg == rpd_pkg::PH_CSUM_LO))
        else $error("result from a silent phase");

    // A dollar while idle starts a packet with an empty sum
    a_new_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == rpd_pkg::PH_IDLE && c == rpd_pkg::CH_DOLLAR)
        |=> (sum_reg == 8'd0 && count_reg == '0))
        else $error("new packet did not clear sum and count");

endmodule

// ===== src/rpd_out_stage.sv =====
// Result register that holds one result word until the sink takes it.
`timescale 1ns / 1ps

module rpd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_fire,
    input  rpd_pkg::result_t res,
    output logic             out_ready,
    output logic             out_valid,
    input  logic             out_stall,
    output rpd_pkg::result_t res_out
);

    logic             valid_reg;
    logic             valid_next;
    rpd_pkg::result_t res_reg;

    // Room when empty or when the held word is taken this cycle
    assign out_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_fire)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// ===== src/remote_debug_packet_deframer.sv =====
// Data path: input register, combinational parser, result register driving out_valid.
// Throughput: one byte per cycle while out_stall is low, set by the framing state update.
// Input and result registers each hold at most one word; a stalled result stalls input.
// Reset (rst_n low, asynchronous) empties both registers and returns to idle
// with sum, count and checksum nibble cleared.
`timescale 1ns / 1ps

module remote_debug_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_type,
    output logic [7:0]  out_byte,
    output logic [11:0] payload_length,
    output logic [7:0]  received_checksum
);

    rpd_pkg::in_word_t word;
    rpd_pkg::result_t  res;
    rpd_pkg::result_t  res_out;
    logic              take;
    logic              res_fire;
    logic              out_ready;

    rpd_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .take     (take),
        .word     (word)
    );

    rpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (word),
        .out_ready (out_ready),
        .take      (take),
        .res_fire  (res_fire),
        .res       (res)
    );

    rpd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_fire  (res_fire),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign result_type       = res_out.rtype;
    assign out_byte          = res_out.data;
    assign payload_length    = res_out.length;
    assign received_checksum = res_out.csum;

endmodule

// ===== sim/rpd_frame_checker.sv =====
// Link monitor for the packet deframer: predicts result words and checks them.
`timescale 1ns / 1ps

module rpd_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  result_type,
    input  logic [7:0]  out_byte,
    input  logic [11:0] payload_length,
    input  logic [7:0]  received_checksum,
    output int          mismatches,
    output int          pending,
    output int          data_words,
    output int          good_words,
    output int          bad_words,
    output int          abort_words
);

    typedef struct {
        rpd_pkg::rtype_t          kind;
        logic [7:0]               data;
        logic [rpd_pkg::LEN_W-1:0] length;
        logic [7:0]               csum;
    } link_result_t;

    link_result_t awaited_results[$];

    // Deframer state as the link should see it
    rpd_pkg::phase_t frame_phase;
    logic [7:0]      payload_sum;
    int              payload_count;
    logic [3:0]      csum_high;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
            return 4'(c - 8'h30);
        if (c inside {[8'h41:8'h46]})
            return 4'(c - 8'h37);
        if (c inside {[8'h61:8'h66]})
            return 4'(c - 8'h57);
        return 4'h0;
    endfunction

    task automatic queue_result(input rpd_pkg::rtype_t kind, input logic [7:0] data,
                                input logic [7:0] csum);
        link_result_t r;
        r.kind   = kind;
        r.data   = data;
        r.length = rpd_pkg::LEN_W'(payload_count);
        r.csum   = csum;
        awaited_results.push_back(r);
    endtask

    // Advance the framing state by one received word
    task automatic track_link_byte(input logic [7:0] c);
        logic [7:0] rx_csum;
        case (frame_phase)
            rpd_pkg::PH_IDLE:
            begin
                if (c == rpd_pkg::CH_DOLLAR)
                begin
                    payload_sum   = 8'h00;
                    payload_count = 0;
                    frame_phase   = rpd_pkg::PH_PAYLOAD;
                end
            end
            rpd_pkg::PH_PAYLOAD:
            begin
                if (c == rpd_pkg::CH_HASH)
                begin
                    frame_phase = rpd_pkg::PH_CSUM_HI;
                end
                else if (payload_count >= rpd_pkg::LINE_BUF_SIZE - 1)
                begin
                    // buffer full: drop the word and abort the packet
                    frame_phase = rpd_pkg::PH_IDLE;
                    queue_result(rpd_pkg::RT_ABORT, rpd_pkg::CH_NONE, 8'h00);
                end
                else
                begin
                    payload_count++;
                    payload_sum = payload_sum + c;
                    queue_result(rpd_pkg::RT_DATA, c, 8'h00);
                end
            end
            rpd_pkg::PH_CSUM_HI:
            begin
                csum_high   = digit_value(c);
                frame_phase = rpd_pkg::PH_CSUM_LO;
            end
            default:
            begin
                rx_csum     = {csum_high, digit_value(c)};
                frame_phase = rpd_pkg::PH_IDLE;
                if (rx_csum == payload_sum)
                    queue_result(rpd_pkg::RT_GOOD, rpd_pkg::CH_PLUS, rx_csum);
                else
                    queue_result(rpd_pkg::RT_BAD, rpd_pkg::CH_MINUS, rx_csum);
            end
        endcase
    endtask

    // Compare the oldest expectation first, then take in the new input word
    always @(posedge clk or negedge rst_n)
    begin
        link_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            frame_phase   = rpd_pkg::PH_IDLE;
            payload_sum   = 8'h00;
            payload_count = 0;
            csum_high     = 4'h0;
            mismatches    = 0;
            pending       = 0;
            data_words    = 0;
            good_words    = 0;
            bad_words     = 0;
            abort_words   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result word: type %0d byte %02h len %0d csum %02h",
                                 result_type, out_byte, payload_length, received_checksum);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    case (want.kind)
                        rpd_pkg::RT_DATA:  data_words++;
                        rpd_pkg::RT_GOOD:  good_words++;
                        rpd_pkg::RT_BAD:   bad_words++;
                        default:           abort_words++;
                    endcase
                    if (result_type != want.kind || out_byte != want.data ||
                        payload_length != want.length || received_checksum != want.csum)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("result mismatch: expected type %0d byte %02h len %0d csum %02h",
                                     want.kind, want.data, want.length, want.csum);
                            $display("                 got type %0d byte %02h len %0d csum %02h",
                                     result_type, out_byte, payload_length, received_checksum);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                track_link_byte(rx_byte);
            pending = awaited_results.size();
        end
    end

endmodule

// ===== sim/remote_debug_packet_deframer_tb.sv =====
// Testbench top for the packet deframer: link stimulus, flow control and verdict.
`timescale 1ns / 1ps

module remote_debug_packet_deframer_tb;

    localparam int RANDOM_WORDS = 1750;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        CK_MATCH,
        CK_WRONG,
        CK_JUNK
    } csum_mode_t;

    typedef logic [7:0] byte_q_t[$];

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_type;
    logic [7:0]  out_byte;
    logic [11:0] payload_length;
    logic [7:0]  received_checksum;

    int mismatches;
    int pending;
    int data_words;
    int good_words;
    int bad_words;
    int abort_words;
    int burst_left;
    int framed_bytes;
    int idle_cycles;

    remote_debug_packet_deframer DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .result_type       (result_type),
        .out_byte          (out_byte),
        .payload_length    (payload_length),
        .received_checksum (received_checksum)
    );

    rpd_frame_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .result_type       (result_type),
        .out_byte          (out_byte),
        .payload_length    (payload_length),
        .received_checksum (received_checksum),
        .mismatches        (mismatches),
        .pending           (pending),
        .data_words        (data_words),
        .good_words        (good_words),
        .bad_words         (bad_words),
        .abort_words       (abort_words)
    );

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = 8'h00;
        out_stall = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10)
            return 8'h30 + nib;
        return (lower ? 8'h61 : 8'h41) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] junk_digit();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
        return c;
    endfunction

    function automatic logic [7:0] payload_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == rpd_pkg::CH_HASH);
        return c;
    endfunction

    // Offer one word at the falling edge and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic send_counted(input logic [7:0] b);
        send_byte(b);
        framed_bytes++;
    endtask

    // Send a whole packet with the chosen kind of checksum
    task automatic send_frame(input byte_q_t body, input csum_mode_t mode, input bit lower);
        logic [7:0] sum;
        logic [7:0] csum;
        sum = 8'h00;
        send_counted(rpd_pkg::CH_DOLLAR);
        foreach (body[i])
        begin
            sum = sum + body[i];
            send_counted(body[i]);
        end
        send_counted(rpd_pkg::CH_HASH);
        if (mode == CK_JUNK)
        begin
            send_counted(junk_digit());
            send_counted(junk_digit());
        end
        else
        begin
            csum = (mode == CK_MATCH) ? sum : sum + 8'($urandom_range(1, 255));
            send_counted(hex_char(csum[7:4], lower));
            send_counted(hex_char(csum[3:0], lower));
        end
    endtask

    // Receiver: switch stall pattern now and then, with a long hold-off at times
    initial
    begin : receiver
        int cyc;
        int hold_left;
        int mode;
        logic stall_now;
        cyc       = 0;
        hold_left = 0;
        mode      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 500 == 0)
                mode = $urandom_range(0, 3);
            if (cyc % 9000 == 1200)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else
            begin
                case (mode)
                    0:       stall_now = 1'b0;
                    1:       stall_now = ($urandom_range(0, 3) == 0);
                    2:       stall_now = ($urandom_range(0, 3) != 0);
                    default: stall_now = ((cyc % 5) < 2);
                endcase
            end
            out_stall <= stall_now;
        end
    end

    // Watchdog: end the run when the link stops moving
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("remote_debug_packet_deframer test failed");
        $finish;
    end

    initial
    begin : stimulus
        byte_q_t body;
        int target;
        int pick;
        int n;
        burst_left   = 0;
        framed_bytes = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // hash outside a packet is ignored
        send_byte(rpd_pkg::CH_HASH);
        // empty payload, then dollar inside a payload and byte extremes
        body = {};
        send_frame(body, CK_MATCH, 1'b0);
        body = '{rpd_pkg::CH_DOLLAR, 8'hff, 8'h00, 8'hb5};
        send_frame(body, CK_MATCH, 1'b0);
        body = '{8'hdb};
        send_frame(body, CK_MATCH, 1'b1);
        // non-hex digits decode as zero: bad on a nonzero sum, good on an empty one
        body = '{8'h11};
        send_frame(body, CK_JUNK, 1'b0);
        body = {};
        send_frame(body, CK_JUNK, 1'b0);

        // longest payload that fits, then one word too many
        body = {};
        repeat (rpd_pkg::LINE_BUF_SIZE - 1) body.push_back(payload_byte());
        send_frame(body, CK_MATCH, 1'b1);
        body.push_back(payload_byte());
        send_frame(body, CK_MATCH, 1'b0);

        // random packets, line noise and cut-off packets
        target = framed_bytes + RANDOM_WORDS;
        while (framed_bytes < target)
        begin
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
            body = {};
            repeat (n) body.push_back(payload_byte());
            if (pick < 60)
                send_frame(body, CK_MATCH, 1'($urandom_range(0, 1)));
            else if (pick < 75)
                send_frame(body, CK_WRONG, 1'($urandom_range(0, 1)));
            else if (pick < 82)
                send_frame(body, CK_JUNK, 1'b0);
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                // cut the packet short so the next dollar lands inside it
                send_counted(rpd_pkg::CH_DOLLAR);
                foreach (body[i])
                    send_counted(body[i]);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_counted(rpd_pkg::CH_HASH);
                    send_counted(hex_char(4'($urandom_range(0, 15)),
                                          1'($urandom_range(0, 1))));
                end
            end
        end
        in_valid <= 1'b0;

        // drain the result words still owed, then let the pipeline settle
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d packet bytes; checked %0d payload words, %0d good and %0d bad",
                 framed_bytes, data_words, good_words, bad_words);
        $display("verdicts, %0d overflow aborts; %0d mismatches", abort_words, mismatches);
        if (mismatches == 0)
            $display("remote_debug_packet_deframer test passed");
        else
            $display("remote_debug_packet_deframer test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/rpd_pkg.sv
src/rpd_in_stage.sv
src/rpd_parser.sv
src/rpd_out_stage.sv
src/remote_debug_packet_deframer.sv
sim/rpd_frame_checker.sv
sim/remote_debug_packet_deframer_tb.sv
